// ===== rtl/ctra_pkg.sv =====
// Shared constants, arctangent table and fixed-point helpers for the CTRA predictor.
// Used by the predictor top level and its reduction, CORDIC and divider cells.
// No dependencies.
package ctra_pkg;

  // CORDIC iterations (12 to 32) and cell counts of the other chains
  localparam int CORDIC_STEPS = 24;
  localparam int NRED         = 18;   // angle reduction steps (quotient bits of the remainder)
  localparam int QBITS        = 41;   // quotient bits kept before clamping

  // datapath widths
  localparam int MW = 49;   // angle magnitude during reduction
  localparam int AW = 34;   // CORDIC x, y, z

  // angle constants, Q4.28 radians
  localparam int ANG_PI      = 843314857;
  localparam int ANG_HALF_PI = 421657428;
  localparam int ANG_TWO_PI  = 1686629713;
  // gain-compensated CORDIC start, Q2.30
  localparam int CORDIC_GAIN = 652032874;

  localparam logic [15:0] BIAS_RESET = 16'd268;

  // pipeline depth up to the last divider cell, and the delay of the coefficient bundle
  localparam int LAT = 32 + CORDIC_STEPS + QBITS;
  localparam int D1  = 19 + CORDIC_STEPS;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } res_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } res32_t;

  // arctangent of 2^-i, Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // shift an exact product right, truncating toward zero, and saturate to 64 bits
  function automatic res_t trunc_sh(input logic signed [127:0] p, input logic [6:0] sh);
    logic [127:0] mag;
    logic [127:0] m;
    res_t         r;
    mag = p[127] ? 128'(-p) : 128'(p);
    m   = mag >> sh;
    if (!p[127]) begin
      r.sat = (m > 128'h7FFF_FFFF_FFFF_FFFF);
      r.val = r.sat ? S64_MAX : $signed(m[63:0]);
    end else begin
      r.sat = (m > 128'h8000_0000_0000_0000);
      r.val = r.sat ? S64_MIN : -$signed(m[63:0]);
    end
    return r;
  endfunction

  // saturating 64-bit add or subtract
  function automatic res_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b,
                                   input logic sub);
    logic signed [64:0] s;
    res_t               r;
    s     = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    r.sat = s[64] ^ s[63];
    r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  // saturate to 32 bits
  function automatic res32_t sat32(input logic signed [63:0] v);
    res32_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.sat = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r.sat = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ctra_rdc_cell.sv =====
// One step of the angle remainder chain: subtract a scaled full turn if it fits.
// Uses ctra_pkg for widths.
module ctra_rdc_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ctra_pkg::MW-1:0]  mag_i,
  input  logic [ctra_pkg::MW-1:0]  thr_i,
  input  logic                     neg_i,
  output logic [ctra_pkg::MW-1:0]  mag_o,
  output logic                     neg_o
);

  logic [ctra_pkg::MW-1:0] mag_d, mag_q;
  logic                    neg_q;

  // drop one multiple of the threshold when the magnitude holds it
  always_comb begin
    mag_d = (mag_i >= thr_i) ? (mag_i - thr_i) : mag_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= neg_i;
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ===== rtl/ctra_cordic_cell.sv =====
// One rotation-mode CORDIC iteration with its own x, y, z registers.
// Uses ctra_pkg for widths.
module ctra_cordic_cell (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [ctra_pkg::AW-1:0] x_i,
  input  logic signed [ctra_pkg::AW-1:0] y_i,
  input  logic signed [ctra_pkg::AW-1:0] z_i,
  input  logic        [4:0]              shift_i,
  input  logic        [31:0]             atan_i,
  input  logic                           flip_i,
  output logic signed [ctra_pkg::AW-1:0] x_o,
  output logic signed [ctra_pkg::AW-1:0] y_o,
  output logic signed [ctra_pkg::AW-1:0] z_o,
  output logic                           flip_o
);

  logic signed [ctra_pkg::AW-1:0] xs, ys, at;
  logic signed [ctra_pkg::AW-1:0] x_d, y_d, z_d, x_q, y_q, z_q;
  logic                           flip_q;

  // rotate toward zero residual angle
  always_comb begin
    xs = x_i >>> shift_i;
    ys = y_i >>> shift_i;
    at = $signed({2'b00, atan_i});
    if (!z_i[ctra_pkg::AW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - at;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      flip_q <= flip_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign flip_o = flip_q;

endmodule

// ===== rtl/ctra_div_cell.sv =====
// One restoring-division step: compare, subtract, shift in a quotient bit.
// Uses ctra_pkg for the quotient width.
module ctra_div_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [64:0]                  rem_i,
  input  logic [62:0]                  den_i,
  input  logic [ctra_pkg::QBITS-1:0]   q_i,
  input  logic                         neg_i,
  input  logic                         clamp_i,
  output logic [64:0]                  rem_o,
  output logic [62:0]                  den_o,
  output logic [ctra_pkg::QBITS-1:0]   q_o,
  output logic                         neg_o,
  output logic                         clamp_o
);

  logic                       ge;
  logic [64:0]                r;
  logic [64:0]                rem_q;
  logic [62:0]                den_q;
  logic [ctra_pkg::QBITS-1:0] q_q;
  logic                       neg_q, clamp_q;

  // subtract the divisor where it fits and double the partial remainder
  always_comb begin
    ge = (rem_i >= {2'b00, den_i});
    r  = ge ? (rem_i - {2'b00, den_i}) : rem_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= {r[63:0], 1'b0};
      den_q   <= den_i;
      q_q     <= {q_i[ctra_pkg::QBITS-2:0], ge};
      neg_q   <= neg_i;
      clamp_q <= clamp_i;
    end
  end

  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign q_o     = q_q;
  assign neg_o   = neg_q;
  assign clamp_o = clamp_q;

endmodule

// ===== rtl/ctra_position_predictor.sv =====
// CTRA position predictor: a fully pipelined unit that takes one request per clock and
// returns one prediction per request, in order. The pipe is built from chains of cells:
// 18 angle-remainder steps, the CORDIC iterations and 41 restoring-division steps per
// coordinate. The output register decouples the sink: the pipe keeps accepting while a
// result waits, and stalls only when the last stage is full and the output is not taken.
// The user must write turn_rate_bias through the cfg port only while the unit is idle;
// the block does not enforce this. Depends on ctra_pkg and the three cell modules.
module ctra_position_predictor (
  input  logic         clk_i,
  input  logic         rst_ni,
  // fields low to high: pos_x, pos_y, heading, speed, accel, turn_rate, frame_time, query_time
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,
  // fields low to high: pred_x, pred_y, pred_heading
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,
  // fields low to high: overflow
  output logic         m_axis_tuser,
  // turn_rate_bias write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  localparam int MW  = ctra_pkg::MW;
  localparam int AW  = ctra_pkg::AW;
  localparam int CS  = ctra_pkg::CORDIC_STEPS;
  localparam int NR  = ctra_pkg::NRED;
  localparam int QB  = ctra_pkg::QBITS;
  localparam int LAT = ctra_pkg::LAT;
  localparam int D1  = ctra_pkg::D1;

  typedef struct packed {
    logic signed [63:0] coef;
    logic signed [63:0] vw;
    logic signed [31:0] a;
    logic signed [49:0] ph;
    logic        [62:0] den;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sat;
  } pay_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [49:0] ph;
    logic        [62:0] den;
    logic               sat;
  } pb_t;

  // merge further saturation into a bundle's flag
  function automatic pb_t add_flag(input pb_t p, input logic s);
    pb_t r;
    r     = p;
    r.sat = p.sat | s;
    return r;
  endfunction

  logic        en;
  logic        acc;
  logic [15:0] bias_q;
  logic        v_q [0:LAT-1];
  logic        out_vq;

  // ---------------------------------------------------------------- control
  assign en            = !out_vq || m_axis_tready || !v_q[LAT-1];
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;
  assign cfg_ready_o   = 1'b1;

  // hold the bias register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= ctra_pkg::BIAS_RESET;
    end else if (cfg_valid_i) begin
      bias_q <= cfg_data_i;
    end
  end

  // advance the valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= s_axis_tvalid;
      for (int i = 1; i < LAT; i++) v_q[i] <= v_q[i-1];
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic signed [31:0] px1, py1, th1, v1, a1, w1;
  logic signed [32:0] dt1, wb1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1 <= s_axis_tdata[31:0];
      py1 <= s_axis_tdata[63:32];
      th1 <= s_axis_tdata[95:64];
      v1  <= s_axis_tdata[127:96];
      a1  <= s_axis_tdata[159:128];
      w1  <= s_axis_tdata[191:160];
      dt1 <= $signed({1'b0, s_axis_tdata[255:224]}) - $signed({1'b0, s_axis_tdata[223:192]});
      wb1 <= $signed({s_axis_tdata[191], s_axis_tdata[191:160]}) + $signed({17'd0, bias_q});
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic signed [64:0] dthp2;
  logic signed [63:0] vwp2;
  logic signed [65:0] sq2;
  logic signed [31:0] px2, py2, th2, a2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dthp2 <= w1 * dt1;
      vwp2  <= v1 * w1;
      sq2   <= wb1 * wb1;
      px2   <= px1;
      py2   <= py1;
      th2   <= th1;
      a2    <= a1;
    end
  end

  // ---------------------------------------------------------------- stage 3: scale
  ctra_pkg::res_t     dth_c, vw_c;
  logic signed [48:0] dth3;
  logic signed [63:0] vw3;
  logic        [62:0] den3;
  logic signed [31:0] px3, py3, th3, a3;

  assign dth_c = ctra_pkg::trunc_sh(128'(dthp2), 7'd16);
  assign vw_c  = ctra_pkg::trunc_sh(128'(vwp2), 7'd12);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dth3 <= dth_c.val[48:0];
      vw3  <= vw_c.val;
      den3 <= (sq2[62:0] == 63'd0) ? 63'd1 : sq2[62:0];
      px3  <= px2;
      py3  <= py2;
      th3  <= th2;
      a3   <= a2;
    end
  end

  // ---------------------------------------------------------------- stage 4: new heading, a*dth parts
  logic signed [49:0] ph4;
  logic signed [56:0] pplo4, pphi4;
  logic signed [63:0] vw4;
  logic        [62:0] den4;
  logic signed [31:0] px4, py4, th4, a4;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph4   <= 50'(th3) + 50'(dth3);
      pplo4 <= a3 * $signed({1'b0, dth3[23:0]});
      pphi4 <= a3 * $signed(dth3[48:24]);
      vw4   <= vw3;
      den4  <= den3;
      px4   <= px3;
      py4   <= py3;
      th4   <= th3;
      a4    <= a3;
    end
  end

  // ---------------------------------------------------------------- stage 5: magnitudes, a*dth
  ctra_pkg::res_t     adth_c;
  logic signed [63:0] adth5, vw5;
  logic               sat5;
  logic        [62:0] den5;
  logic signed [49:0] ph5;
  logic signed [31:0] px5, py5, a5;
  logic [MW-1:0]      rth_mag [0:NR];
  logic [MW-1:0]      rph_mag [0:NR];
  logic               rth_neg [0:NR];
  logic               rph_neg [0:NR];

  assign adth_c = ctra_pkg::trunc_sh((128'(pphi4) <<< 24) + 128'(pplo4), 7'd12);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rth_mag[0] <= th4[31] ? MW'(-33'(th4)) : MW'(th4);
      rth_neg[0] <= th4[31];
      rph_mag[0] <= ph4[49] ? MW'(-ph4) : MW'(ph4);
      rph_neg[0] <= ph4[49];
      adth5      <= adth_c.val;
      sat5       <= adth_c.sat;
      vw5        <= vw4;
      den5       <= den4;
      ph5        <= ph4;
      px5        <= px4;
      py5        <= py4;
      a5         <= a4;
    end
  end

  // ---------------------------------------------------------------- stage 6: coefficient
  ctra_pkg::res_t coef_c;
  pay_t           pay6;
  pay_t           dl1 [0:D1-1];

  assign coef_c = ctra_pkg::sat_add(vw5, adth5, 1'b0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay6.coef <= coef_c.val;
      pay6.vw   <= vw5;
      pay6.a    <= a5;
      pay6.ph   <= ph5;
      pay6.den  <= den5;
      pay6.px   <= px5;
      pay6.py   <= py5;
      pay6.sat  <= sat5 | coef_c.sat;
    end
  end

  // hold the coefficient bundle while the angles go through reduction and CORDIC
  always_ff @(posedge clk_i) begin
    if (en) begin
      dl1[0] <= pay6;
      for (int i = 1; i < D1; i++) dl1[i] <= dl1[i-1];
    end
  end

  // ---------------------------------------------------------------- angle remainder chains
  for (genvar j = 0; j < NR; j++) begin : g_rdc
    localparam logic [MW-1:0] THR = MW'(ctra_pkg::ANG_TWO_PI) << (NR - 1 - j);
    ctra_rdc_cell u_th (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (rth_mag[j]),
      .thr_i (THR),
      .neg_i (rth_neg[j]),
      .mag_o (rth_mag[j+1]),
      .neg_o (rth_neg[j+1])
    );
    ctra_rdc_cell u_ph (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (rph_mag[j]),
      .thr_i (THR),
      .neg_i (rph_neg[j]),
      .mag_o (rph_mag[j+1]),
      .neg_o (rph_neg[j+1])
    );
  end

  // ---------------------------------------------------------------- fold into a half turn
  logic signed [AW-1:0] cx [0:1][0:CS];
  logic signed [AW-1:0] cy [0:1][0:CS];
  logic signed [AW-1:0] cz [0:1][0:CS];
  logic                 cf [0:1][0:CS];
  logic signed [AW-1:0] fr [0:1];
  logic signed [AW-1:0] fz [0:1];
  logic                 ff [0:1];

  always_comb begin
    fr[0] = rth_neg[NR] ? -AW'(rth_mag[NR]) : AW'(rth_mag[NR]);
    fr[1] = rph_neg[NR] ? -AW'(rph_mag[NR]) : AW'(rph_mag[NR]);
    for (int k = 0; k < 2; k++) begin
      if (fr[k] > AW'(ctra_pkg::ANG_PI)) begin
        fr[k] = fr[k] - AW'(ctra_pkg::ANG_TWO_PI);
      end
      if (fr[k] < -AW'(ctra_pkg::ANG_PI)) begin
        fr[k] = fr[k] + AW'(ctra_pkg::ANG_TWO_PI);
      end
      ff[k] = 1'b0;
      if (fr[k] > AW'(ctra_pkg::ANG_HALF_PI)) begin
        fr[k] = fr[k] - AW'(ctra_pkg::ANG_PI);
        ff[k] = 1'b1;
      end else if (fr[k] < -AW'(ctra_pkg::ANG_HALF_PI)) begin
        fr[k] = fr[k] + AW'(ctra_pkg::ANG_PI);
        ff[k] = 1'b1;
      end
      fz[k] = fr[k] <<< 2;
    end
  end

  // seed each CORDIC chain
  for (genvar k = 0; k < 2; k++) begin : g_seed
    always_ff @(posedge clk_i) begin
      if (en) begin
        cx[k][0] <= AW'(ctra_pkg::CORDIC_GAIN);
        cy[k][0] <= '0;
        cz[k][0] <= fz[k];
        cf[k][0] <= ff[k];
      end
    end
  end

  // ---------------------------------------------------------------- CORDIC chains
  for (genvar k = 0; k < 2; k++) begin : g_ang
    for (genvar j = 0; j < CS; j++) begin : g_step
      ctra_cordic_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (en),
        .x_i     (cx[k][j]),
        .y_i     (cy[k][j]),
        .z_i     (cz[k][j]),
        .shift_i (5'(j)),
        .atan_i  (ctra_pkg::atan_q30(5'(j))),
        .flip_i  (cf[k][j]),
        .x_o     (cx[k][j+1]),
        .y_o     (cy[k][j+1]),
        .z_o     (cz[k][j+1]),
        .flip_o  (cf[k][j+1])
      );
    end
  end

  // ---------------------------------------------------------------- sine and cosine
  logic signed [AW-1:0] s0, c0, s1, c1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0 <= cf[0][CS] ? -cy[0][CS] : cy[0][CS];
      c0 <= cf[0][CS] ? -cx[0][CS] : cx[0][CS];
      s1 <= cf[1][CS] ? -cy[1][CS] : cy[1][CS];
      c1 <= cf[1][CS] ? -cx[1][CS] : cx[1][CS];
    end
  end

  // ---------------------------------------------------------------- numerator products
  logic signed [63:0]   op [0:7];
  logic signed [AW-1:0] mv [0:7];
  logic signed [63:0]   aq;
  logic signed [65:0]   pph [0:7];
  logic signed [66:0]   ppl [0:7];
  ctra_pkg::res_t       mr  [0:7];
  logic signed [63:0]   mk  [0:3][0:7];
  pb_t                  pbq [0:6];
  logic                 psat;

  assign aq = 64'(dl1[D1-1].a) <<< 16;

  always_comb begin
    op[0] = dl1[D1-1].coef; mv[0] = s1;
    op[1] = aq;             mv[1] = c1;
    op[2] = dl1[D1-1].vw;   mv[2] = s0;
    op[3] = aq;             mv[3] = c0;
    op[4] = dl1[D1-1].coef; mv[4] = c1;
    op[5] = aq;             mv[5] = s1;
    op[6] = dl1[D1-1].vw;   mv[6] = c0;
    op[7] = aq;             mv[7] = s0;
  end

  // split each 64-bit operand into two 32-bit halves and form a partial product with each
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        pph[i] <= $signed(op[i][63:32]) * mv[i];
        ppl[i] <= $signed({1'b0, op[i][31:0]}) * mv[i];
      end
      pbq[0].px  <= dl1[D1-1].px;
      pbq[0].py  <= dl1[D1-1].py;
      pbq[0].ph  <= dl1[D1-1].ph;
      pbq[0].den <= dl1[D1-1].den;
      pbq[0].sat <= dl1[D1-1].sat;
    end
  end

  always_comb begin
    psat = 1'b0;
    for (int i = 0; i < 8; i++) begin
      mr[i] = ctra_pkg::trunc_sh((128'(pph[i]) <<< 32) + 128'(ppl[i]), 7'd30);
      psat  = psat | mr[i].sat;
    end
  end

  // combine the partial products into scaled, saturated terms
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 8; i++) mk[0][i] <= mr[i].val;
      pbq[1] <= add_flag(pbq[0], psat);
    end
  end

  // ---------------------------------------------------------------- numerator sums, in order
  logic signed [63:0] nx_q [0:3];
  logic signed [63:0] ny_q [0:3];
  ctra_pkg::res_t     ax [0:3];
  ctra_pkg::res_t     ay [0:3];

  always_comb begin
    ax[0] = ctra_pkg::sat_add(mk[0][0], mk[0][1], 1'b0);
    ay[0] = ctra_pkg::sat_add(64'sd0, mk[0][4], 1'b1);
    ax[1] = ctra_pkg::sat_add(nx_q[0], mk[1][2], 1'b1);
    ay[1] = ctra_pkg::sat_add(ny_q[0], mk[1][5], 1'b0);
    ax[2] = ctra_pkg::sat_add(nx_q[1], mk[2][3], 1'b1);
    ay[2] = ctra_pkg::sat_add(ny_q[1], mk[2][6], 1'b0);
    ax[3] = '{sat: 1'b0, val: nx_q[2]};
    ay[3] = ctra_pkg::sat_add(ny_q[2], mk[3][7], 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        nx_q[k] <= ax[k].val;
        ny_q[k] <= ay[k].val;
      end
      pbq[2] <= add_flag(pbq[1], ax[0].sat | ay[0].sat);
      pbq[3] <= add_flag(pbq[2], ax[1].sat | ay[1].sat);
      pbq[4] <= add_flag(pbq[3], ax[2].sat | ay[2].sat);
      pbq[5] <= add_flag(pbq[4], ax[3].sat | ay[3].sat);
      mk[1] <= mk[0];
      mk[2] <= mk[1];
      mk[3] <= mk[2];
    end
  end

  // ---------------------------------------------------------------- divider setup
  logic [63:0]        nmag [0:1];
  logic [64:0]        dv_rem   [0:1][0:QB];
  logic [62:0]        dv_den   [0:1][0:QB];
  logic [QB-1:0]      dv_q     [0:1][0:QB];
  logic               dv_neg   [0:1][0:QB];
  logic               dv_clamp [0:1][0:QB];
  pb_t                dl2 [0:QB-1];

  assign nmag[0] = nx_q[3][63] ? 64'(-nx_q[3]) : 64'(nx_q[3]);
  assign nmag[1] = ny_q[3][63] ? 64'(-ny_q[3]) : 64'(ny_q[3]);

  // a numerator of twice the divisor or more already exceeds the quotient cap
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem[0][0]   <= {1'b0, nmag[0]};
      dv_rem[1][0]   <= {1'b0, nmag[1]};
      dv_neg[0][0]   <= nx_q[3][63];
      dv_neg[1][0]   <= ny_q[3][63];
      dv_clamp[0][0] <= (nmag[0] >= {pbq[5].den, 1'b0});
      dv_clamp[1][0] <= (nmag[1] >= {pbq[5].den, 1'b0});
      dv_den[0][0]   <= pbq[5].den;
      dv_den[1][0]   <= pbq[5].den;
      dv_q[0][0]     <= '0;
      dv_q[1][0]     <= '0;
      pbq[6] <= pbq[5];
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_lane
    for (genvar j = 0; j < QB; j++) begin : g_div
      ctra_div_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (en),
        .rem_i   (dv_rem[k][j]),
        .den_i   (dv_den[k][j]),
        .q_i     (dv_q[k][j]),
        .neg_i   (dv_neg[k][j]),
        .clamp_i (dv_clamp[k][j]),
        .rem_o   (dv_rem[k][j+1]),
        .den_o   (dv_den[k][j+1]),
        .q_o     (dv_q[k][j+1]),
        .neg_o   (dv_neg[k][j+1]),
        .clamp_o (dv_clamp[k][j+1])
      );
    end
  end

  // hold positions, heading and flags alongside the divider
  always_ff @(posedge clk_i) begin
    if (en) begin
      dl2[0] <= pbq[6];
      for (int i = 1; i < QB; i++) dl2[i] <= dl2[i-1];
    end
  end

  // ---------------------------------------------------------------- final sums and saturation
  logic [QB:0]         qc  [0:1];
  logic signed [QB+1:0] qs [0:1];
  logic signed [QB+2:0] ps [0:1];
  ctra_pkg::res32_t    rx, ry, rh;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      qc[k] = (dv_clamp[k][QB] || (dv_q[k][QB] > (QB)'(1) << (QB - 1)))
            ? (((QB + 1)'(1) << (QB - 1)) + (QB + 1)'(1)) : {1'b0, dv_q[k][QB]};
      qs[k] = dv_neg[k][QB] ? -$signed({1'b0, qc[k]}) : $signed({1'b0, qc[k]});
    end
    ps[0] = (QB + 3)'(dl2[QB-1].px) + (QB + 3)'(qs[0]);
    ps[1] = (QB + 3)'(dl2[QB-1].py) + (QB + 3)'(qs[1]);
    rx    = ctra_pkg::sat32(64'(ps[0]));
    ry    = ctra_pkg::sat32(64'(ps[1]));
    rh    = ctra_pkg::sat32(64'(dl2[QB-1].ph));
  end

  // load the output register when it is free or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (!out_vq || m_axis_tready) begin
      out_vq <= v_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!out_vq || m_axis_tready) && v_q[LAT-1]) begin
      m_axis_tdata <= {rh.val, ry.val, rx.val};
      m_axis_tuser <= dl2[QB-1].sat | rx.sat | ry.sat | rh.sat;
    end
  end

  assign m_axis_tvalid = out_vq;

`ifndef SYNTHESIS
  // the input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

  // an accepted request enters the pipe
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> v_q[0])
    else $error("accepted request lost at pipe entry");

  // a finished item is never dropped while the output is held
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAT-1] && !en) |=> v_q[LAT-1])
    else $error("last stage dropped during stall");

  // a result taken with a waiting item is replaced on the next cycle
  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAT-1] && m_axis_tvalid && m_axis_tready) |=> m_axis_tvalid)
    else $error("output not refilled");
`endif

endmodule

// ===== dv/tb_ctra_position_predictor.sv =====
// Testbench for ctra_position_predictor: directed and random prediction requests with a
// scoreboard that recomputes every CTRA prediction bit for bit. Depends on ctra_pkg and the RTL.
`timescale 1ns / 1ps

module tb_ctra_position_predictor;

  // fields low to high: pos_x .. query_time
  typedef struct packed {
    logic [31:0] qt;
    logic [31:0] ft;
    logic [31:0] w;
    logic [31:0] a;
    logic [31:0] v;
    logic [31:0] th;
    logic [31:0] py;
    logic [31:0] px;
  } track_req_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] h;
    logic [31:0] y;
    logic [31:0] x;
  } track_pred_t;

  // Recomputes predictions and checks the unit's results in order
  class ctra_scoreboard;
    logic [15:0]  bias;
    bit           sat_hit;
    int           errors;
    int           n_req;
    int           n_res;
    int           n_ovf;
    track_pred_t  pending[$];
    longint       atan_tab[32];

    function new();
      bias = ctra_pkg::BIAS_RESET;
      for (int i = 0; i < 32; i++) atan_tab[i] = longint'(ctra_pkg::atan_q30(5'(i)));
    endfunction

    function longint mul_shift(longint a, longint b, int sh);
      logic signed [127:0] p;
      logic [127:0]        m;
      p = 128'(signed'(a)) * 128'(signed'(b));
      m = p[127] ? 128'(-p) : 128'(p);
      m = m >> sh;
      if (!p[127]) begin
        if (m > 128'h7FFF_FFFF_FFFF_FFFF) begin sat_hit = 1; return ctra_pkg::S64_MAX; end
        return longint'(m[63:0]);
      end
      if (m > 128'h8000_0000_0000_0000) begin sat_hit = 1; return ctra_pkg::S64_MIN; end
      return -longint'(m[63:0]);
    endfunction

    function longint add_sat(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(signed'(a)) + 65'(signed'(b));
      if (s[64] != s[63]) begin
        sat_hit = 1;
        return s[64] ? ctra_pkg::S64_MIN : ctra_pkg::S64_MAX;
      end
      return s[63:0];
    endfunction

    function longint sub_sat(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(signed'(a)) - 65'(signed'(b));
      if (s[64] != s[63]) begin
        sat_hit = 1;
        return s[64] ? ctra_pkg::S64_MIN : ctra_pkg::S64_MAX;
      end
      return s[63:0];
    endfunction

    // reduce to [-pi/2, pi/2], rotate, then undo the half turn
    function void sin_cos(longint ang, output longint s, output longint c);
      longint r, x, y, z, xs, ys;
      bit     flip;
      r = ang % ctra_pkg::ANG_TWO_PI;
      x = ctra_pkg::CORDIC_GAIN;
      y = 0;
      flip = 0;
      if (r > ctra_pkg::ANG_PI) r -= ctra_pkg::ANG_TWO_PI;
      if (r < -ctra_pkg::ANG_PI) r += ctra_pkg::ANG_TWO_PI;
      if (r > ctra_pkg::ANG_HALF_PI) begin r -= ctra_pkg::ANG_PI; flip = 1; end
      else if (r < -ctra_pkg::ANG_HALF_PI) begin r += ctra_pkg::ANG_PI; flip = 1; end
      z = r * 4;
      for (int i = 0; i < ctra_pkg::CORDIC_STEPS && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin x -= ys; y += xs; z -= atan_tab[i]; end
        else begin x += ys; y -= xs; z += atan_tab[i]; end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function longint divide_q40(longint num, logic [63:0] den);
      logic [63:0]  mag;
      logic [127:0] q;
      mag = num < 0 ? 64'(-num) : 64'(num);
      q = {24'd0, mag, 40'd0} / {64'd0, den};
      if (q > 128'd1099511627776) q = 128'd1099511627777;
      return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) begin sat_hit = 1; return 32'h7FFF_FFFF; end
      if (v < -64'sd2147483648) begin sat_hit = 1; return 32'h8000_0000; end
      return v[31:0];
    endfunction

    function track_pred_t predict(track_req_t r);
      longint      px, py, th, v, a, w, dt, dth, ph, s0, c0, s1, c1;
      longint      vw, coef, aq, nx, ny, wb;
      logic [63:0] den;
      track_pred_t p;
      px = longint'(signed'(r.px));
      py = longint'(signed'(r.py));
      th = longint'(signed'(r.th));
      v  = longint'(signed'(r.v));
      a  = longint'(signed'(r.a));
      w  = longint'(signed'(r.w));
      dt = longint'({32'd0, r.qt}) - longint'({32'd0, r.ft});
      sat_hit = 0;
      dth = mul_shift(w, dt, 16);
      ph = th + dth;
      sin_cos(th, s0, c0);
      sin_cos(ph, s1, c1);
      vw = mul_shift(v, w, 12);
      coef = add_sat(vw, mul_shift(a, dth, 12));
      aq = a * 65536;
      nx = mul_shift(coef, s1, 30);
      nx = add_sat(nx, mul_shift(aq, c1, 30));
      nx = sub_sat(nx, mul_shift(vw, s0, 30));
      nx = sub_sat(nx, mul_shift(aq, c0, 30));
      ny = sub_sat(0, mul_shift(coef, c1, 30));
      ny = add_sat(ny, mul_shift(aq, s1, 30));
      ny = add_sat(ny, mul_shift(vw, c0, 30));
      ny = sub_sat(ny, mul_shift(aq, s0, 30));
      wb = w + longint'({48'd0, bias});
      den = 64'(wb * wb);
      if (den == 0) den = 1;
      p.x = clamp32(px + divide_q40(nx, den));
      p.y = clamp32(py + divide_q40(ny, den));
      p.h = clamp32(ph);
      p.ovf = sat_hit;
      return p;
    endfunction

    function void note_request(track_req_t r);
      pending.push_back(predict(r));
      n_req++;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s at result %0d: got %h, want %h", what, n_res, got, want);
      errors++;
    endtask

    task check_result(track_pred_t got);
      track_pred_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.x, '0);
      end else begin
        want = pending.pop_front();
        if (got.x !== want.x) report("pred_x", got.x, want.x);
        if (got.y !== want.y) report("pred_y", got.y, want.y);
        if (got.h !== want.h) report("pred_heading", got.h, want.h);
        if (got.ovf !== want.ovf) report("overflow", got.ovf, want.ovf);
        if (want.ovf) n_ovf++;
      end
      n_res++;
    endtask
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  ctra_scoreboard sb = new();
  int             hold_left = 0;
  int             stall_mode = 0;

  ctra_position_predictor dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // sink: check accepted results, stall on a drifting pattern or a long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result({m_axis_tuser, m_axis_tdata});
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // offer one request and hold it until taken
  task send_request(track_req_t r, int gap);
    s_axis_tdata  <= r;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (ctra_pkg::LAT + 10) @(posedge clk_i);
  endtask

  task write_bias(logic [15:0] b);
    cfg_data_i  <= b;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.bias = b;
  endtask

  function track_req_t random_request();
    track_req_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 9) < 6) begin
      // plausible track: modest speed, turn rate and look-ahead
      r.px = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      r.py = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      r.v  = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
      r.a  = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      r.w  = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
      r.qt = r.ft + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    end
    if ($urandom_range(0, 29) == 0) r.w = -$signed({16'd0, sb.bias});
    return r;
  endfunction

  task run_random(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) burst = $urandom_range(1, 40);
      burst--;
      send_request(random_request(), burst == 0 ? $urandom_range(0, 12) : 0);
    end
  endtask

  initial begin
    track_req_t r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: zeros, extremes, zero denominator, backward query, huge look-ahead
    r = '0;
    send_request(r, 0);
    r = {32'd65536, 32'd0, 32'd268435456, 32'd0, 32'd655360, 32'd0, 32'd0, 32'd0};
    send_request(r, 0);
    r = {8{32'hFFFF_FFFF}};
    send_request(r, 0);
    r = {32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_request(r, 1);
    r = {32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_request(r, 0);
    r = {32'd100, 32'd200000, -32'sd268, 32'd65536, 32'd327680, 32'd0, 32'd0, 32'd0};
    send_request(r, 0);
    r = {32'd5000, 32'd5000, -32'sd268, 32'd0, 32'd0, 32'd1, 32'd7, 32'd9};
    send_request(r, 2);
    r = {32'd0, 32'd131072, 32'd53687091, 32'hFFFF_0000, 32'd1310720, 32'd843314857,
         32'hFFF0_0000, 32'h0010_0000};
    send_request(r, 0);
    r = {32'd131072, 32'd0, 32'hF000_0000, 32'd65536, 32'hFFEC_0000, 32'hCDBA_D5A8,
         32'd12345, 32'd0};
    send_request(r, 0);
    r = {32'h0000_8000, 32'd0, 32'd1, 32'd0, 32'd65536, 32'd421657428, 32'd0, 32'd0};
    send_request(r, 0);
    drain();

    write_bias(16'd0);
    r = '0;
    send_request(r, 0);
    r = {32'd65536, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0};
    send_request(r, 0);
    run_random(250);
    drain();

    write_bias(16'hFFFF);
    r = {32'd65536, 32'd0, -32'sd65535, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    send_request(r, 0);
    run_random(300);

    // long sink hold-off while requests keep coming, then a full drain
    hold_left = 400;
    run_random(250);
    drain();

    write_bias(16'($urandom));
    run_random(300);
    drain();

    write_bias(ctra_pkg::BIAS_RESET);
    run_random(300);
    drain();

    $display("Covered %0d requests, %0d results (%0d saturating), bias 0, max, random, reset.",
             sb.n_req, sb.n_res, sb.n_ovf);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
